### rtl/rsms_pkg.sv
// ----------------------------------------------------------------------------
// rsms_pkg
// Shared types and constants for the range smoothing / mode steering block.
// ----------------------------------------------------------------------------
package rsms_pkg;

    localparam int RANGE_W = 13;
    localparam int LINE_W  = 12;
    localparam int FRAC_W  = 8;
    localparam int AVG_W   = RANGE_W + FRAC_W;
    localparam int ALPHA_W = 9;
    localparam int SPEED_W = 7;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam logic [SPEED_W-1:0] SPEED_FULL = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_HIGH = 7'd90;
    localparam logic [SPEED_W-1:0] SPEED_LOW  = 7'd70;
    localparam logic [SPEED_W-1:0] SPEED_STOP = 7'd0;
    localparam logic [SPEED_W-1:0] SPEED_INIT = 7'd80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKUP    = 3'd5;

    typedef enum logic [1:0] {
        MODE_ACQUIRE  = 2'd0,
        MODE_ATTACK   = 2'd1,
        MODE_SURVIVE  = 2'd2,
        MODE_BACKUP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        DIR_FORWARD   = 3'd0,
        DIR_BACKWARD  = 3'd1,
        DIR_SPIN_CW   = 3'd2,
        DIR_PIVOT_CW  = 3'd3,
        DIR_PIVOT_CCW = 3'd4
    } dir_t;

    // what the filter stage decided for a transaction
    typedef enum logic [1:0] {
        KIND_NORMAL  = 2'd0,
        KIND_SURVIVE = 2'd1,
        KIND_BACKUP  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_q8;
        logic [RANGE_W-1:0] attack_range;
        logic [LINE_W-1:0]  line_threshold;
        logic [RANGE_W-1:0] coarse_threshold;
        logic [RANGE_W-1:0] fine_threshold;
        logic [CNT_W-1:0]   backup_periods;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_left;
        logic [RANGE_W-1:0] range_front_left;
        logic [RANGE_W-1:0] range_front_right;
        logic [RANGE_W-1:0] range_right;
        logic [LINE_W-1:0]  line_left;
        logic [LINE_W-1:0]  line_right;
    } sample_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [AVG_W-1:0] avg_left;
        logic [AVG_W-1:0] avg_front_left;
        logic [AVG_W-1:0] avg_front_right;
        logic [AVG_W-1:0] avg_right;
    } filt_t;

endpackage

### rtl/rsms_sample_if.sv
// ----------------------------------------------------------------------------
// rsms_sample_if
// Sample channel: four range distances and two line levels per transaction.
// ----------------------------------------------------------------------------
interface rsms_sample_if
    import rsms_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_left;
    logic [RANGE_W-1:0] range_front_left;
    logic [RANGE_W-1:0] range_front_right;
    logic [RANGE_W-1:0] range_right;
    logic [LINE_W-1:0]  line_left;
    logic [LINE_W-1:0]  line_right;

    modport source (
        output valid, range_left, range_front_left, range_front_right, range_right,
               line_left, line_right,
        input  ready
    );

    modport sink (
        input  valid, range_left, range_front_left, range_front_right, range_right,
               line_left, line_right,
        output ready
    );
endinterface

### rtl/rsms_command_if.sv
// ----------------------------------------------------------------------------
// rsms_command_if
// Command channel: mode, motor direction and two motor speeds.
// ----------------------------------------------------------------------------
interface rsms_command_if
    import rsms_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [2:0]         direction;
    logic [SPEED_W-1:0] speed_left;
    logic [SPEED_W-1:0] speed_right;

    modport source (
        output valid, mode, direction, speed_left, speed_right,
        input  ready
    );

    modport sink (
        input  valid, mode, direction, speed_left, speed_right,
        output ready
    );
endinterface

### rtl/rsms_filter.sv
// ----------------------------------------------------------------------------
// rsms_filter
// Exponential averaging of the four ranges, line test and backup counter.
// ----------------------------------------------------------------------------
module rsms_filter
    import rsms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    up_valid,
    output logic    up_ready,
    input  sample_t up_data,
    input  logic    down_ready,
    output filt_t   filt
);

    logic               valid_reg, valid_next;
    kind_t              kind_reg, kind_next;
    logic [AVG_W-1:0]   avg_reg  [4];
    logic [AVG_W-1:0]   avg_next [4];
    logic [RANGE_W-1:0] rng      [4];
    logic [CNT_W-1:0]   backup_count_reg, backup_count_next;
    logic [ALPHA_W-1:0] alpha_sat;
    logic [ALPHA_W-1:0] alpha_rest;
    logic               take;
    logic               line_hit;

    // avg' = (a*(s<<8) + (256-a)*avg + 128) >> 8
    function automatic logic [AVG_W-1:0] smooth(
        input logic [ALPHA_W-1:0] a,
        input logic [ALPHA_W-1:0] b,
        input logic [RANGE_W-1:0] s,
        input logic [AVG_W-1:0]   avg
    );
        logic [AVG_W+ALPHA_W:0] sum;
        sum = (AVG_W+ALPHA_W+1)'(a) * (AVG_W+ALPHA_W+1)'({s, {FRAC_W{1'b0}}})
            + (AVG_W+ALPHA_W+1)'(b) * (AVG_W+ALPHA_W+1)'(avg)
            + (AVG_W+ALPHA_W+1)'(1 << (FRAC_W-1));
        return sum[AVG_W+FRAC_W-1:FRAC_W];
    endfunction

    assign alpha_sat  = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
    assign alpha_rest = ALPHA_ONE - alpha_sat;

    assign rng[0] = up_data.range_left;
    assign rng[1] = up_data.range_front_left;
    assign rng[2] = up_data.range_front_right;
    assign rng[3] = up_data.range_right;

    assign up_ready = !valid_reg || down_ready;
    assign take     = up_valid && up_ready;
    assign line_hit = (up_data.line_left < cfg.line_threshold)
                   || (up_data.line_right < cfg.line_threshold);

    always_comb
    begin
        valid_next        = valid_reg;
        kind_next         = kind_reg;
        backup_count_next = backup_count_reg;
        for (int i = 0; i < 4; i++)
        begin
            avg_next[i] = avg_reg[i];
        end

        if (take)
        begin
            valid_next = 1'b1;
            if (backup_count_reg != '0)
            begin
                // reversing: sample values are dropped, only the backup kind goes out
                backup_count_next = backup_count_reg - 1'b1;
                kind_next         = KIND_BACKUP;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    avg_next[i] = smooth(alpha_sat, alpha_rest, rng[i], avg_reg[i]);
                end
                if (line_hit)
                begin
                    backup_count_next = cfg.backup_periods;
                    kind_next         = KIND_SURVIVE;
                end
                else
                begin
                    kind_next = KIND_NORMAL;
                end
            end
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            kind_reg         <= KIND_NORMAL;
            backup_count_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                avg_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg        <= valid_next;
            kind_reg         <= kind_next;
            backup_count_reg <= backup_count_next;
            for (int i = 0; i < 4; i++)
            begin
                avg_reg[i] <= avg_next[i];
            end
        end
    end

    assign filt.valid           = valid_reg;
    assign filt.kind            = kind_reg;
    assign filt.avg_left        = avg_reg[0];
    assign filt.avg_front_left  = avg_reg[1];
    assign filt.avg_front_right = avg_reg[2];
    assign filt.avg_right       = avg_reg[3];

endmodule

### rtl/range_smoothing_mode_steering.sv
// ----------------------------------------------------------------------------
// range_smoothing_mode_steering
// Smooths range readings and picks the drive mode and motor command.
// ----------------------------------------------------------------------------
// Usage:
//   sample  : valid/ready sink, one transaction per control period.
//   command : valid/ready source, exactly one command per sample.
//   cfg_we/cfg_index/cfg_data : register writes, only while the block is idle.
// Pipeline: input register -> filter register (averages, line test, backup
//   counter) -> command register (attack / acquisition decision, held speeds).
// Throughput is one transaction per cycle while command.ready is high. The
//   averaging multipliers set the filter stage, the side-difference subtract
//   and compares set the command stage.
// Each stage has its own valid bit, so bubbles close up and a new sample is
//   taken while a finished command waits. With command.ready low the pipeline
//   fills and sample.ready drops after three held transactions.
// Reset: averages and backup count clear, held speeds go to 80/80, registers
//   take their default values; no command is pending.
// ----------------------------------------------------------------------------
module range_smoothing_mode_steering
    import rsms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rsms_sample_if.sink          sample,
    rsms_command_if.source       command
);

    cfg_t               cfg_reg;
    sample_t            s1_data_reg;
    logic               s1_valid_reg;
    logic               s1_ready;
    logic               s2_ready;
    filt_t              filt;
    logic               out_ready;
    logic               s3_take;

    logic               out_valid_reg;
    mode_t              out_mode_reg, out_mode_next;
    dir_t               out_dir_reg, out_dir_next;
    logic [SPEED_W-1:0] out_sl_reg, out_sl_next;
    logic [SPEED_W-1:0] out_sr_reg, out_sr_next;
    logic [SPEED_W-1:0] held_sl_reg, held_sl_next;
    logic [SPEED_W-1:0] held_sr_reg, held_sr_next;

    logic               attack;
    logic [AVG_W-1:0]   diff_lr;
    logic [AVG_W-1:0]   diff_rl;
    logic               neg;
    logic [RANGE_W-1:0] mag_mm;

    // ------------------------------------------------------------ config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q8           <= 9'd154;
            cfg_reg.attack_range       <= 13'd600;
            cfg_reg.line_threshold     <= 12'd2000;
            cfg_reg.coarse_threshold   <= 13'd100;
            cfg_reg.fine_threshold     <= 13'd10;
            cfg_reg.backup_periods     <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA:    cfg_reg.alpha_q8           <= cfg_data[ALPHA_W-1:0];
                CFG_DIST_THR: cfg_reg.attack_range       <= cfg_data[RANGE_W-1:0];
                CFG_LINE_THR: cfg_reg.line_threshold     <= cfg_data[LINE_W-1:0];
                CFG_COARSE:   cfg_reg.coarse_threshold   <= cfg_data[RANGE_W-1:0];
                CFG_FINE:     cfg_reg.fine_threshold     <= cfg_data[RANGE_W-1:0];
                CFG_BACKUP:   cfg_reg.backup_periods     <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------ input stage
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && s1_ready)
        begin
            s1_data_reg.range_left        <= sample.range_left;
            s1_data_reg.range_front_left  <= sample.range_front_left;
            s1_data_reg.range_front_right <= sample.range_front_right;
            s1_data_reg.range_right       <= sample.range_right;
            s1_data_reg.line_left         <= sample.line_left;
            s1_data_reg.line_right        <= sample.line_right;
        end
    end

    // ----------------------------------------------------- filter stage
    rsms_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (s1_valid_reg),
        .up_ready   (s2_ready),
        .up_data    (s1_data_reg),
        .down_ready (out_ready),
        .filt       (filt)
    );

    // ---------------------------------------------------- command stage
    assign out_ready = !out_valid_reg || command.ready;
    assign s3_take   = filt.valid && out_ready;

    // mean < thr<<8 is the same as the whole-mm part being below thr
    assign attack = (filt.avg_front_left[AVG_W-1:FRAC_W] < cfg_reg.attack_range)
                 || (filt.avg_front_right[AVG_W-1:FRAC_W] < cfg_reg.attack_range);

    assign diff_lr = filt.avg_left - filt.avg_right;
    assign diff_rl = filt.avg_right - filt.avg_left;
    assign neg     = filt.avg_left < filt.avg_right;
    // magnitude truncated to whole mm, i.e. rounding toward zero
    assign mag_mm  = neg ? diff_rl[AVG_W-1:FRAC_W] : diff_lr[AVG_W-1:FRAC_W];

    always_comb
    begin
        out_mode_next = MODE_ACQUIRE;
        out_dir_next  = DIR_FORWARD;
        out_sl_next   = held_sl_reg;
        out_sr_next   = held_sr_reg;
        held_sl_next  = held_sl_reg;
        held_sr_next  = held_sr_reg;

        case (filt.kind)
            KIND_BACKUP:
            begin
                out_mode_next = MODE_BACKUP;
                out_dir_next  = DIR_BACKWARD;
                out_sl_next   = SPEED_FULL;
                out_sr_next   = SPEED_FULL;
            end
            KIND_SURVIVE:
            begin
                out_mode_next = MODE_SURVIVE;
                out_dir_next  = DIR_BACKWARD;
                out_sl_next   = SPEED_FULL;
                out_sr_next   = SPEED_FULL;
                held_sl_next  = SPEED_FULL;
                held_sr_next  = SPEED_FULL;
            end
            KIND_NORMAL:
            begin
                if (attack)
                begin
                    out_mode_next = MODE_ATTACK;
                    out_dir_next  = DIR_FORWARD;
                    if (mag_mm > cfg_reg.coarse_threshold)
                    begin
                        out_sl_next = neg ? SPEED_FULL : SPEED_STOP;
                        out_sr_next = neg ? SPEED_STOP : SPEED_FULL;
                    end
                    else if (mag_mm > cfg_reg.fine_threshold)
                    begin
                        out_sl_next = neg ? SPEED_HIGH : SPEED_LOW;
                        out_sr_next = neg ? SPEED_LOW  : SPEED_HIGH;
                    end
                    else
                    begin
                        out_sl_next = SPEED_FULL;
                        out_sr_next = SPEED_FULL;
                    end
                    held_sl_next = out_sl_next;
                    held_sr_next = out_sr_next;
                end
                else
                begin
                    out_mode_next = MODE_ACQUIRE;
                    if (filt.avg_front_left > filt.avg_front_right)
                    begin
                        out_dir_next = DIR_PIVOT_CCW;
                    end
                    else if (filt.avg_front_left < filt.avg_front_right)
                    begin
                        out_dir_next = DIR_PIVOT_CW;
                    end
                    else
                    begin
                        out_dir_next = DIR_FORWARD;
                    end
                end
            end
            default:
            begin
                out_mode_next = MODE_ACQUIRE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_sl_reg   <= SPEED_INIT;
            held_sr_reg   <= SPEED_INIT;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= filt.valid;
            end
            if (s3_take)
            begin
                held_sl_reg <= held_sl_next;
                held_sr_reg <= held_sr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_take)
        begin
            out_mode_reg <= out_mode_next;
            out_dir_reg  <= out_dir_next;
            out_sl_reg   <= out_sl_next;
            out_sr_reg   <= out_sr_next;
        end
    end

    assign command.valid       = out_valid_reg;
    assign command.mode        = out_mode_reg;
    assign command.direction   = out_dir_reg;
    assign command.speed_left  = out_sl_reg;
    assign command.speed_right = out_sr_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_smoothing_mode_steering. A short table of
// directed transactions and register writes runs first, then phases of
// scene-based random samples under several register settings. Each command is
// checked against its row's own command or an in-bench model of the averages,
// mode choice and held speeds; channels stall at random but in the calm phase.
// ----------------------------------------------------------------------------
module tb_top;
    import rsms_pkg::*;

    typedef struct packed {
        mode_t              mode;
        dir_t               direction;
        logic [SPEED_W-1:0] speed_left;
        logic [SPEED_W-1:0] speed_right;
    } cmd_t;

    // typed: the row carries its own expected command
    typedef struct packed {
        bit   typed;
        cmd_t cmd;
    } tag_t;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        int unsigned          value;
        sample_t              s;
        bit                   typed;
        cmd_t                 want;
    } plan_row_t;

    localparam int   SAMPLE_W  = $bits(sample_t);
    localparam cmd_t NO_CMD    = '0;
    localparam cmd_t ACQ_HELD  = '{MODE_ACQUIRE, DIR_FORWARD, SPEED_INIT, SPEED_INIT};
    localparam cmd_t SURVIVING = '{MODE_SURVIVE, DIR_BACKWARD, SPEED_FULL, SPEED_FULL};
    localparam cmd_t BACKING   = '{MODE_BACKUP, DIR_BACKWARD, SPEED_FULL, SPEED_FULL};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   calm;

    rsms_sample_if  sample_ch ();
    rsms_command_if command_ch ();

    range_smoothing_mode_steering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .command   (command_ch)
    );

    // register shadows
    logic [ALPHA_W-1:0] r_alpha;
    logic [RANGE_W-1:0] r_dist;
    logic [LINE_W-1:0]  r_line;
    logic [RANGE_W-1:0] r_coarse;
    logic [RANGE_W-1:0] r_fine;
    logic [CNT_W-1:0]   r_backup;

    // model state
    logic [AVG_W-1:0]   mean_l, mean_fl, mean_fr, mean_r;
    logic [SPEED_W-1:0] held_sl, held_sr;
    logic [CNT_W-1:0]   backup_left;

    tag_t      tag_q[$];
    cmd_t      pending_cmds[$];
    plan_row_t plan[$];
    int        failures;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [AVG_W-1:0] smoothed(logic [AVG_W-1:0] mean,
                                                  logic [RANGE_W-1:0] x);
        longint unsigned a, xs, total;
        a = (r_alpha > ALPHA_ONE) ? 256 : r_alpha;
        xs = x;
        total = a * (xs << 8) + (256 - a) * mean + 128;
        return total[8 +: AVG_W];
    endfunction

    function automatic cmd_t steer(sample_t s);
        int ml, mr, diff, c, f;
        logic [SPEED_W-1:0] sl, sr;
        if (backup_left != 0)
        begin
            backup_left = backup_left - 1'b1;
            return BACKING;
        end
        mean_l  = smoothed(mean_l, s.range_left);
        mean_fl = smoothed(mean_fl, s.range_front_left);
        mean_fr = smoothed(mean_fr, s.range_front_right);
        mean_r  = smoothed(mean_r, s.range_right);
        if (s.line_left < r_line || s.line_right < r_line)
        begin
            held_sl = SPEED_FULL;
            held_sr = SPEED_FULL;
            backup_left = r_backup;
            return SURVIVING;
        end
        if (mean_fl < {r_dist, 8'd0} || mean_fr < {r_dist, 8'd0})
        begin
            ml = mean_l;
            mr = mean_r;
            diff = (ml - mr) / 256;     // whole mm, toward zero
            c = r_coarse;
            f = r_fine;
            if (diff > c)
            begin
                sl = SPEED_STOP;
                sr = SPEED_FULL;
            end
            else if (diff < -c)
            begin
                sl = SPEED_FULL;
                sr = SPEED_STOP;
            end
            else if (diff > f)
            begin
                sl = SPEED_LOW;
                sr = SPEED_HIGH;
            end
            else if (diff < -f)
            begin
                sl = SPEED_HIGH;
                sr = SPEED_LOW;
            end
            else
            begin
                sl = SPEED_FULL;
                sr = SPEED_FULL;
            end
            held_sl = sl;
            held_sr = sr;
            return '{MODE_ATTACK, DIR_FORWARD, sl, sr};
        end
        if (mean_fl > mean_fr)
            return '{MODE_ACQUIRE, DIR_PIVOT_CCW, held_sl, held_sr};
        if (mean_fl < mean_fr)
            return '{MODE_ACQUIRE, DIR_PIVOT_CW, held_sl, held_sr};
        return '{MODE_ACQUIRE, DIR_FORWARD, held_sl, held_sr};
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    // accepted samples feed the model; accepted commands are checked
    always @(posedge clk)
    begin
        sample_t seen;
        tag_t    tag;
        cmd_t    got, want;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            seen = '{sample_ch.range_left, sample_ch.range_front_left,
                     sample_ch.range_front_right, sample_ch.range_right,
                     sample_ch.line_left, sample_ch.line_right};
            tag = tag_q.pop_front();
            want = steer(seen);
            pending_cmds.push_back(tag.typed ? tag.cmd : want);
        end
        if (rst_n && command_ch.valid && command_ch.ready)
        begin
            got = '{mode_t'(command_ch.mode), dir_t'(command_ch.direction),
                    command_ch.speed_left, command_ch.speed_right};
            if (pending_cmds.size() == 0)
                note_failure($sformatf("unexpected command: mode %0d dir %0d speeds %0d/%0d",
                                       got.mode, got.direction, got.speed_left,
                                       got.speed_right));
            else
            begin
                want = pending_cmds.pop_front();
                if (got.mode != want.mode || got.direction != want.direction ||
                    got.speed_left != want.speed_left ||
                    got.speed_right != want.speed_right)
                    note_failure($sformatf(
                        "command mismatch (exp/got): mode %0d/%0d dir %0d/%0d left %0d/%0d right %0d/%0d",
                        want.mode, got.mode, want.direction, got.direction,
                        want.speed_left, got.speed_left, want.speed_right, got.speed_right));
            end
        end
    end

    always @(posedge clk)
        if (rst_n)
            command_ch.ready <= calm || ($urandom_range(0, 99) >= 33);

    task automatic send_sample(input sample_t s, input bit typed, input cmd_t want);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid             <= 1'b1;
        sample_ch.range_left        <= s.range_left;
        sample_ch.range_front_left  <= s.range_front_left;
        sample_ch.range_front_right <= s.range_front_right;
        sample_ch.range_right       <= s.range_right;
        sample_ch.line_left         <= s.line_left;
        sample_ch.line_right        <= s.line_right;
        tag_q.push_back('{typed, want});
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // step the clock first so the last accepted transaction is already queued
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ALPHA:    r_alpha  = value[ALPHA_W-1:0];
            CFG_DIST_THR: r_dist   = value[RANGE_W-1:0];
            CFG_LINE_THR: r_line   = value[LINE_W-1:0];
            CFG_COARSE:   r_coarse = value[RANGE_W-1:0];
            CFG_FINE:     r_fine   = value[RANGE_W-1:0];
            CFG_BACKUP:   r_backup = value[CNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic plan_item(input int l, fl, fr, r, ll, lr,
                             input bit typed, input cmd_t want);
        plan_row_t row;
        row.is_write = 1'b0;
        row.s = '{l[RANGE_W-1:0], fl[RANGE_W-1:0], fr[RANGE_W-1:0], r[RANGE_W-1:0],
                  ll[LINE_W-1:0], lr[LINE_W-1:0]};
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endtask

    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        plan_row_t row;
        row = '{1'b1, idx, value, '0, 1'b0, NO_CMD};
        plan.push_back(row);
    endtask

    function automatic int clip(int v);
        return (v < 0) ? 0 : ((v > 8191) ? 8191 : v);
    endfunction

    function automatic int pick_line();
        if (r_line > 0 && $urandom_range(0, 29) == 0)
            return $urandom_range(0, r_line - 1);   // edge seen
        return $urandom_range(r_line, 4095);
    endfunction

    // bursts of one scene: far target, near target with a chosen side
    // difference, or pure noise
    task automatic run_random(input int count);
        sample_t s;
        int n, k, span, scene, sel, bl, br, bf, bg, off, c, f;
        n = 0;
        c = r_coarse;
        f = r_fine;
        while (n < count)
        begin
            scene = $urandom_range(0, 9);
            span = $urandom_range(2, 25);
            bl = $urandom_range(0, 8191);
            if (scene <= 3)
            begin
                bf = $urandom_range(r_dist, 8191);
                bg = (scene == 1) ? bf : $urandom_range(r_dist, 8191);
                br = $urandom_range(0, 8191);
            end
            else
            begin
                bf = $urandom_range(0, (r_dist > 0) ? r_dist - 1 : 0);
                bg = ($urandom_range(0, 1) == 0) ? bf : $urandom_range(0, 8191);
                sel = $urandom_range(0, 5);
                case (sel)
                    0: off = c + 1;
                    1: off = c;
                    2: off = f + 1;
                    3: off = f;
                    4: off = $urandom_range(0, c + f + 30);
                    default: off = 0;
                endcase
                if ($urandom_range(0, 1) == 0)
                    off = -off;
                br = clip(bl - off);
            end
            for (k = 0; k < span && n < count; k++)
            begin
                if (scene == 0)
                    s = SAMPLE_W'({$urandom, $urandom, $urandom});
                else
                begin
                    s.range_left        = bl[RANGE_W-1:0];
                    s.range_right       = br[RANGE_W-1:0];
                    s.range_front_left  = RANGE_W'(clip(bf + $urandom_range(0, 40) - 20));
                    s.range_front_right = (bg == bf) ? s.range_front_left
                                        : RANGE_W'(clip(bg + $urandom_range(0, 40) - 20));
                    s.line_left         = LINE_W'(pick_line());
                    s.line_right        = LINE_W'(pick_line());
                end
                send_sample(s, 1'b0, NO_CMD);
                n++;
            end
        end
    endtask

    task automatic apply_settings(input int unsigned a, d, l, c, f, b);
        drain();
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_DIST_THR, d);
        write_reg(CFG_LINE_THR, l);
        write_reg(CFG_COARSE, c);
        write_reg(CFG_FINE, f);
        write_reg(CFG_BACKUP, b);
    endtask

    initial
    begin
        int unsigned fixed_set [4][6];
        int k, ph, fine_pick;
        fixed_set = '{'{154, 600, 2000, 100, 10, 10},
                      '{0, 8191, 0, 0, 0, 255},
                      '{511, 8191, 4095, 8191, 8191, 1},
                      '{200, 1000, 1, 0, 0, 255}};
        failures = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.range_left = '0;
        sample_ch.range_front_left = '0;
        sample_ch.range_front_right = '0;
        sample_ch.range_right = '0;
        sample_ch.line_left = '0;
        sample_ch.line_right = '0;
        command_ch.ready = 1'b0;
        r_alpha = 9'd154;
        r_dist = 13'd600;
        r_line = 12'd2000;
        r_coarse = 13'd100;
        r_fine = 13'd10;
        r_backup = 8'd10;
        mean_l = '0;
        mean_fl = '0;
        mean_fr = '0;
        mean_r = '0;
        held_sl = SPEED_INIT;
        held_sr = SPEED_INIT;
        backup_left = '0;

        // directed table, reset register values first
        plan_item(8191, 8191, 8191, 8191, 4095, 4095, 1'b1, ACQ_HELD);
        plan_item(0, 8191, 0, 8191, 4095, 4095, 1'b0, NO_CMD);
        plan_item(0, 0, 0, 0, 1999, 4095, 1'b1, SURVIVING);
        for (k = 0; k < 10; k++)    // samples ignored while backing up
            plan_item(k * 800, 8191 - k * 800, k * 3, 8191, 0, k * 400, 1'b1, BACKING);
        plan_write(CFG_BACKUP, 0);
        plan_item(8191, 8191, 8191, 8191, 4095, 0, 1'b1, SURVIVING);
        plan_item(500, 100, 8191, 300, 2000, 2000, 1'b0, NO_CMD);  // level at threshold
        plan_write(CFG_ALPHA, 300);         // saturates: mean follows sample
        plan_write(CFG_DIST_THR, 8191);
        plan_item(8191, 0, 0, 0, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_STOP, SPEED_FULL});
        plan_item(0, 0, 0, 8191, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_FULL, SPEED_STOP});
        plan_item(101, 0, 0, 0, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_STOP, SPEED_FULL});
        plan_item(100, 0, 0, 0, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_LOW, SPEED_HIGH});
        plan_item(0, 0, 0, 11, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_HIGH, SPEED_LOW});
        plan_item(10, 0, 0, 0, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_FULL, SPEED_FULL});
        plan_item(0, 0, 0, 10, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_FULL, SPEED_FULL});
        plan_item(0, 0, 0, 100, 4095, 4095, 1'b1,
                  '{MODE_ATTACK, DIR_FORWARD, SPEED_HIGH, SPEED_LOW});
        // acquisition keeps the last attack speeds
        plan_item(0, 8191, 8191, 0, 4095, 4095, 1'b1,
                  '{MODE_ACQUIRE, DIR_FORWARD, SPEED_HIGH, SPEED_LOW});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
                send_sample(plan[i].s, plan[i].typed, plan[i].want);
        end

        for (ph = 0; ph < 8; ph++)
        begin
            if (ph < 4)
                apply_settings(fixed_set[ph][0], fixed_set[ph][1], fixed_set[ph][2],
                               fixed_set[ph][3], fixed_set[ph][4], fixed_set[ph][5]);
            else
            begin
                fine_pick = $urandom_range(0, 400);
                apply_settings($urandom_range(0, 511), $urandom_range(0, 2000),
                               $urandom_range(0, 4095), $urandom_range(0, 400),
                               fine_pick, $urandom_range(0, 6));
            end
            calm = (ph == 5);
            run_random(185);
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
